// ===== src/sfc_pkg.sv =====
// shared types and constants of the sensor frame checksum parser
package sfc_pkg;

  typedef enum logic [2:0] {
    PHASE_IDLE = 3'b001,
    PHASE_HEAD = 3'b010,
    PHASE_DATA = 3'b100
  } phase_t;

  localparam logic [7:0] HEADER_FIRST_RESET  = 8'h55;
  localparam logic [7:0] HEADER_SECOND_RESET = 8'h53;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_HEADER_FIRST  = 1'b0;
  localparam logic REG_HEADER_SECOND = 1'b1;

  localparam int unsigned PAYLOAD_W = 64;

endpackage

// ===== src/sensor_frame_checksum_parser.sv =====
// Use: serial bytes enter on rx_byte (in_valid / in_stall), one byte a transfer.
// The parser hunts for the header pair (header_first, header_second), collects
// PAYLOAD_BYTES payload bytes, then compares the next byte with the 8-bit sum of
// header and payload. A good frame gives one transfer on payload (out_valid /
// out_stall), first payload byte in bits 7:0, unused upper bytes zero; a bad
// frame gives nothing. Either way the parser goes back to hunting.
// Throughput: one byte per cycle while in_stall is low, set by the single state register update.
// The result is in the output register in the cycle after the checksum byte
// is taken.
// A stalled result holds in the output register while further bytes are taken;
// only a checksum byte, good or bad, is held off by in_stall, and only while
// the output register is still full and stalled.
// APB-style registers, pready always high: header_first 0x0, header_second 0x4.
// The user writes them only while the parser is idle; the block does not enforce it.
// Reset (rst, synchronous): parser idle, no result pending, headers 0x55 / 0x53.
module sensor_frame_checksum_parser #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfc_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sfc_pkg::PAYLOAD_W-1:0]   payload
);

  localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PAYLOAD_BYTES);

  logic [7:0]                    header_first;
  logic [7:0]                    header_second;
  sfc_pkg::phase_t               phase;
  sfc_pkg::phase_t               phase_next;
  logic [CNT_W-1:0]              byte_count;
  logic [CNT_W-1:0]              byte_count_next;
  logic [7:0]                    running_sum;
  logic [7:0]                    running_sum_next;
  logic [sfc_pkg::PAYLOAD_W-1:0] payload_shift;
  logic [sfc_pkg::PAYLOAD_W-1:0] payload_shift_next;
  logic                          in_accept;
  logic                          frame_good;
  logic                          cfg_write;
  logic                          at_checksum;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == sfc_pkg::REG_HEADER_FIRST) begin
      prdata = {24'd0, header_first};
    end else begin
      prdata = {24'd0, header_second};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= sfc_pkg::HEADER_FIRST_RESET;
      header_second <= sfc_pkg::HEADER_SECOND_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == sfc_pkg::REG_HEADER_FIRST) begin
        header_first <= pwdata[7:0];
      end else begin
        header_second <= pwdata[7:0];
      end
    end
  end

  // only the checksum byte can produce a result, so only it waits on a full output
  assign at_checksum = (phase == sfc_pkg::PHASE_DATA) && (byte_count == LAST_CNT);
  assign in_stall    = at_checksum && out_valid && out_stall;
  assign in_accept   = in_valid && !in_stall;

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    running_sum_next   = running_sum;
    payload_shift_next = payload_shift;
    frame_good         = 1'b0;
    case (phase)
      sfc_pkg::PHASE_IDLE: begin
        if (rx_byte == header_first) begin
          phase_next = sfc_pkg::PHASE_HEAD;
        end
      end
      sfc_pkg::PHASE_HEAD: begin
        if (rx_byte == header_second) begin
          byte_count_next    = '0;
          payload_shift_next = '0;
          running_sum_next   = header_first + header_second;
          phase_next         = sfc_pkg::PHASE_DATA;
        end else begin
          phase_next = sfc_pkg::PHASE_IDLE;
        end
      end
      sfc_pkg::PHASE_DATA: begin
        if (byte_count != LAST_CNT) begin
          for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            if (byte_count == CNT_W'(i)) begin
              payload_shift_next[8*i +: 8] = rx_byte;
            end
          end
          running_sum_next = running_sum + rx_byte;
          byte_count_next  = byte_count + 1'b1;
        end else begin
          frame_good = (rx_byte == running_sum);
          phase_next = sfc_pkg::PHASE_IDLE;
        end
      end
      default: begin
        phase_next = sfc_pkg::PHASE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= sfc_pkg::PHASE_IDLE;
      byte_count  <= '0;
      running_sum <= '0;
    end else if (in_accept) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      payload_shift <= payload_shift_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && frame_good) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && frame_good) begin
      payload <= payload_shift;
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LAST_CNT)
    else $error("payload byte count beyond frame length");

  a_result_from_checksum: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && at_checksum))
    else $error("result appeared without an accepted checksum byte");

  a_header_starts_frame: assert property (@(posedge clk) disable iff (rst)
    in_accept && phase == sfc_pkg::PHASE_HEAD && rx_byte == header_second
    |=> phase == sfc_pkg::PHASE_DATA && byte_count == '0)
    else $error("second header byte did not start payload collection");

  a_checksum_ends_frame: assert property (@(posedge clk) disable iff (rst)
    in_accept && at_checksum |=> phase == sfc_pkg::PHASE_IDLE)
    else $error("parser did not return to hunting after checksum byte");

endmodule

// ===== dv/sensor_frame_checksum_parser_tb.sv =====
// self-checking testbench for the sensor frame checksum parser
`timescale 1ns / 100ps

module sensor_frame_checksum_parser_tb;

  localparam int unsigned NBYTES = 8;

  // tracks the parser state and holds the payloads of good frames still to come
  class frame_scoreboard;
    logic [7:0]       hdr_first;
    logic [7:0]       hdr_second;
    sfc_pkg::phase_t  phase;
    logic [3:0]       taken;
    logic [7:0]       sum;
    logic [63:0]      shift;
    logic [63:0]      good_frames[$];
    int               mismatches;

    function new();
      hdr_first  = sfc_pkg::HEADER_FIRST_RESET;
      hdr_second = sfc_pkg::HEADER_SECOND_RESET;
      phase      = sfc_pkg::PHASE_IDLE;
      taken      = '0;
      sum        = '0;
      shift      = '0;
      mismatches = 0;
    endfunction

    function void set_header(logic sel, logic [7:0] value);
      if (sel == sfc_pkg::REG_HEADER_FIRST) begin
        hdr_first = value;
      end else begin
        hdr_second = value;
      end
    endfunction

    function int pending();
      return good_frames.size();
    endfunction

    function void report(string what, logic [63:0] exp_val, logic [63:0] act_val);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s: expected %h, got %h", $realtime, what, exp_val, act_val);
      end
    endfunction

    // one accepted rx byte
    function void take_byte(logic [7:0] b);
      case (phase)
        sfc_pkg::PHASE_IDLE: begin
          if (b == hdr_first) phase = sfc_pkg::PHASE_HEAD;
        end
        sfc_pkg::PHASE_HEAD: begin
          if (b == hdr_second) begin
            taken = '0;
            shift = '0;
            sum   = hdr_first + hdr_second;
            phase = sfc_pkg::PHASE_DATA;
          end else begin
            // no resync on a repeated first header byte
            phase = sfc_pkg::PHASE_IDLE;
          end
        end
        sfc_pkg::PHASE_DATA: begin
          if (int'(taken) < NBYTES) begin
            shift[8*int'(taken) +: 8] = b;
            sum   = sum + b;
            taken = taken + 4'd1;
          end else begin
            if (b == sum) good_frames.push_back(shift);
            phase = sfc_pkg::PHASE_IDLE;
          end
        end
        default: phase = sfc_pkg::PHASE_IDLE;
      endcase
    endfunction

    // one accepted result transfer
    function void check_payload(logic [63:0] act_val);
      logic [63:0] exp_val;
      if (good_frames.size() == 0) begin
        report("result with no good frame pending", '0, act_val);
      end else begin
        exp_val = good_frames.pop_front();
        if (act_val !== exp_val) report("payload mismatch", exp_val, act_val);
      end
    endfunction

    function void check_register(logic sel, logic [7:0] act_val);
      logic [7:0] exp_val;
      exp_val = (sel == sfc_pkg::REG_HEADER_FIRST) ? hdr_first : hdr_second;
      if (act_val !== exp_val) report("header register readback", exp_val, act_val);
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [sfc_pkg::ADDR_W-1:0]    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_stall;
  logic [7:0]                    rx_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [sfc_pkg::PAYLOAD_W-1:0] payload;

  frame_scoreboard sb;
  int  sent_items;
  bit  idle_on;
  bit  hold_req;

  sensor_frame_checksum_parser dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .payload   (payload)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("** sensor_frame_checksum_parser: FAILED **");
    $finish;
  end

  // result side: random stall bursts plus the occasional long hold
  initial begin
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_payload(payload);
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 60;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 6) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(b);
    sent_items++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_body();
    logic [63:0] body;
    for (int i = 0; i < NBYTES; i++) body[8*i +: 8] = pick_byte();
    return body;
  endfunction

  task automatic send_frame(input logic [63:0] body, input bit good);
    logic [7:0] csum;
    csum = sb.hdr_first + sb.hdr_second;
    send_byte(sb.hdr_first);
    send_byte(sb.hdr_second);
    for (int i = 0; i < NBYTES; i++) begin
      send_byte(body[8*i +: 8]);
      csum = csum + body[8*i +: 8];
    end
    if (!good) csum = csum ^ 8'($urandom_range(1, 255));
    send_byte(csum);
  endtask

  task automatic apb_write(input logic sel, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_header(sel, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_read_check(input logic sel);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.check_register(sel, prdata[7:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_headers(input logic [7:0] first, input logic [7:0] second);
    apb_write(sfc_pkg::REG_HEADER_FIRST, first);
    apb_write(sfc_pkg::REG_HEADER_SECOND, second);
    apb_read_check(sfc_pkg::REG_HEADER_FIRST);
    apb_read_check(sfc_pkg::REG_HEADER_SECOND);
  endtask

  // bring the parser back to hunting and let every pending result drain
  task automatic settle_parser();
    while (sb.phase != sfc_pkg::PHASE_IDLE) begin
      if (sb.phase == sfc_pkg::PHASE_HEAD) begin
        send_byte(~sb.hdr_second);
      end else begin
        send_byte(pick_byte());
      end
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_traffic(input int n_items, input bit with_hold);
    int target;
    int r;
    target = sent_items + n_items;
    if (with_hold) begin
      // long output hold while good frames keep coming, so the input backs up
      hold_req = 1'b1;
      repeat (4) send_frame(pick_body(), 1'b1);
    end
    while (sent_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame(pick_body(), $urandom_range(0, 4) != 0);
      end else if (r < 80) begin
        send_byte(sb.hdr_first);
        send_byte(pick_byte());
      end else if (r < 90) begin
        // truncated frame, whatever follows is taken as payload
        send_byte(sb.hdr_first);
        send_byte(sb.hdr_second);
        repeat ($urandom_range(0, NBYTES - 1)) send_byte(pick_byte());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) begin
            send_byte(sb.hdr_first);
          end else begin
            send_byte(pick_byte());
          end
        end
      end
    end
  endtask

  initial begin
    logic [7:0] h;
    sb         = new();
    sent_items = 0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    rx_byte    = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: good frame with extreme bytes, wrong second header, bad checksum
    send_frame(64'h5355FE7F_8001FF00, 1'b1);
    send_byte(sfc_pkg::HEADER_FIRST_RESET);
    send_byte(sfc_pkg::HEADER_FIRST_RESET);
    send_byte(sfc_pkg::HEADER_SECOND_RESET);
    send_frame(64'hFFFFFFFF_FFFFFFFF, 1'b0);

    run_traffic(250, 1'b1);
    settle_parser();
    set_headers(8'h00, 8'hFF);
    run_traffic(200, 1'b0);
    settle_parser();
    set_headers(8'hFF, 8'h00);
    run_traffic(200, 1'b0);
    settle_parser();
    // equal header bytes
    h = 8'($urandom);
    set_headers(h, h);
    run_traffic(150, 1'b0);
    settle_parser();
    set_headers(8'($urandom), 8'($urandom));
    run_traffic(100, 1'b1);
    settle_parser();
    set_headers(sfc_pkg::HEADER_FIRST_RESET, sfc_pkg::HEADER_SECOND_RESET);
    idle_on = 1'b0;
    run_traffic(150, 1'b0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("** sensor_frame_checksum_parser: PASSED **");
    end else begin
      $display("** sensor_frame_checksum_parser: FAILED **");
    end
    $finish;
  end

endmodule
